>>> rtl/core/slab_entry_allocator_unit_defines.svh
// assertion macros shared by the slab entry allocator rtl
`ifndef SLAB_ENTRY_ALLOCATOR_UNIT_DEFINES_SVH
`define SLAB_ENTRY_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SEA_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
  else $error("slab allocator check failed");
`define SEA_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("slab allocator check failed");
`else
`define SEA_ASSERT(lbl, prop)
`define SEA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/core/sea_pkg.sv
// constants and helpers for the slab entry allocator
package sea_pkg;
  localparam int NUM_SLOTS   = 16;
  localparam int MAX_ENTRIES = 32;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int SPTR_W = SLOT_W + 1;
  localparam int EIDX_W = $clog2(MAX_ENTRIES);
  localparam int EPTR_W = EIDX_W + 1;
  localparam int CNT_W  = EIDX_W + 1;
  localparam int LINK_DEPTH = NUM_SLOTS * MAX_ENTRIES;
  localparam int LINK_AW    = SLOT_W + EIDX_W;

  localparam logic [SPTR_W-1:0] SNULL = SPTR_W'(NUM_SLOTS);
  localparam logic [EPTR_W-1:0] ENULL = EPTR_W'(MAX_ENTRIES);

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_REAP  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_SLOT = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  function automatic logic [CNT_W-1:0] clamp_epb(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] x;
    x = v;
    if (x == '0) x = CNT_W'(1);
    if (x > CNT_W'(MAX_ENTRIES)) x = CNT_W'(MAX_ENTRIES);
    return x;
  endfunction
endpackage

>>> rtl/core/slab_entry_allocator_unit.sv
// slab entry allocator top level: request sequencer, slab lists and link ram
//
// input channel (in_valid / in_stall) carries one request: allocate, free or
// reap. result channel (out_valid / out_stall) returns exactly one result per
// request. cfg_wr_en / cfg_wr_data set entries_per_slab; a write is dropped
// while any slab is active, 0 reads as 1 and values above 32 read as 32
// a small sequencer steps through the slab link registers and the per-entry
// link ram. allocate passes through an open and a pop step, plus a link step
// when a recycled entry is popped, since the link ram read is registered;
// free passes through a check step and, when the slab has to move, a relink
// step; reap through a release step. an output step then moves the result
// into the output register. input is stalled while a request is in progress
// reset (synchronous, rst_n low) leaves every slot idle, all lists empty and
// entries_per_slab at 32. the link ram needs no clearing: only entries pushed
// by a free are ever read back
// a stalled result holds in the output register; the next request may be
// taken meanwhile and its result waits in the sequencer until the register
// frees up
module slab_entry_allocator_unit
  import sea_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [3:0]        in_free_slot,
  input  logic [4:0]        in_free_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [3:0]        out_got_slot,
  output logic [4:0]        out_got_index,
  output logic              out_slab_opened,
  output logic              out_slab_released,
  input  logic              cfg_wr_en,
  input  logic [5:0]        cfg_wr_data
);
`include "slab_entry_allocator_unit_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_AL_OPEN, S_AL_POP, S_AL_LINK, S_FR_CHK, S_FR_LINK, S_REAP, S_OUT
  } state_t;

  state_t state_r;

  // request latched at transfer and sequencer working registers
  logic [SLOT_W-1:0] fslot_r;
  logic [EIDX_W-1:0] fidx_r;
  logic [SLOT_W-1:0] cur_r;
  logic              full_mode_r;

  // slab bookkeeping
  logic [CNT_W-1:0]  epb_r;
  logic              active_r [NUM_SLOTS];
  logic [CNT_W-1:0]  used_r   [NUM_SLOTS];
  logic [EPTR_W-1:0] rhead_r  [NUM_SLOTS];
  logic [CNT_W-1:0]  untch_r  [NUM_SLOTS];
  logic [SPTR_W-1:0] next_r   [NUM_SLOTS];
  logic [SPTR_W-1:0] prev_r   [NUM_SLOTS];
  logic [SPTR_W-1:0] head_r, fos_r, tail_r;

  // pending result and output register
  logic [1:0]        res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [EIDX_W-1:0] res_idx_r;
  logic              res_open_r, res_rel_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [EIDX_W-1:0] out_idx_r;
  logic              out_open_r, out_rel_r;

  // link ram
  logic              lk_we;
  logic [LINK_AW-1:0] lk_waddr, lk_raddr;
  logic [EPTR_W-1:0] lk_wdata, lk_rdata;

  // lowest idle slot
  logic              any_active, idle_found;
  logic [SLOT_W-1:0] idle_slot;

  always_comb begin
    any_active = 1'b0;
    idle_found = 1'b0;
    idle_slot  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (active_r[i]) any_active = 1'b1;
      else begin
        idle_found = 1'b1;
        idle_slot  = SLOT_W'(i);
      end
    end
  end

  // free entry write and recycled entry pop share the link ram
  assign lk_we    = (state_r == S_FR_CHK) && active_r[fslot_r] && (used_r[fslot_r] != '0) &&
                    ({1'b0, fidx_r} < epb_r);
  assign lk_waddr = {fslot_r, fidx_r};
  assign lk_wdata = rhead_r[fslot_r];
  assign lk_raddr = {cur_r, rhead_r[cur_r][EIDX_W-1:0]};

  sea_ram #(.WIDTH(EPTR_W), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk    (clk),
    .wr_en  (lk_we),
    .wr_addr(lk_waddr),
    .wr_data(lk_wdata),
    .rd_addr(lk_raddr),
    .rd_data(lk_rdata)
  );

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    logic [SLOT_W-1:0] s, ns, ps, ts;
    logic [SPTR_W-1:0] p, n, n2;
    logic              bad, full_before;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      epb_r       <= CNT_W'(MAX_ENTRIES);
      head_r      <= SNULL;
      fos_r       <= SNULL;
      tail_r      <= SNULL;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        active_r[i] <= 1'b0;
        used_r[i]   <= '0;
        rhead_r[i]  <= ENULL;
        untch_r[i]  <= '0;
        next_r[i]   <= SNULL;
        prev_r[i]   <= SNULL;
      end
    end else begin
      // the result stage reloads the register itself
      if (out_valid_r && !out_stall && (state_r != S_OUT)) out_valid_r <= 1'b0;
      if (cfg_wr_en && !any_active) epb_r <= clamp_epb(cfg_wr_data);

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            fslot_r      <= in_free_slot;
            fidx_r       <= in_free_index;
            res_status_r <= ST_OK;
            res_slot_r   <= '0;
            res_idx_r    <= '0;
            res_open_r   <= 1'b0;
            res_rel_r    <= 1'b0;
            case (in_req_type)
              REQ_ALLOC: state_r <= S_AL_OPEN;
              REQ_FREE:  state_r <= S_FR_CHK;
              REQ_REAP:  state_r <= S_REAP;
              default:   state_r <= S_OUT;
            endcase
          end
        end

        // pick the first slab with room, or open the lowest idle slot at the tail, else report no slot
        S_AL_OPEN: begin
          if (fos_r != SNULL) begin
            cur_r   <= fos_r[SLOT_W-1:0];
            state_r <= S_AL_POP;
          end else if (!idle_found) begin
            res_status_r <= ST_NO_SLOT;
            state_r      <= S_OUT;
          end else begin
            s = idle_slot;
            active_r[s] <= 1'b1;
            used_r[s]   <= '0;
            rhead_r[s]  <= ENULL;
            untch_r[s]  <= epb_r;
            next_r[s]   <= SNULL;
            fos_r       <= {1'b0, s};
            if (tail_r != SNULL) begin
              ts = tail_r[SLOT_W-1:0];
              prev_r[s]  <= tail_r;
              next_r[ts] <= {1'b0, s};
            end else begin
              prev_r[s] <= SNULL;
              head_r    <= {1'b0, s};
            end
            tail_r     <= {1'b0, s};
            cur_r      <= s;
            res_open_r <= 1'b1;
            state_r    <= S_AL_POP;
          end
        end

        // recycled entries first, then untouched ones counting down
        S_AL_POP: begin
          s = cur_r;
          res_slot_r <= s;
          used_r[s]  <= used_r[s] + CNT_W'(1);
          if ((used_r[s] + CNT_W'(1)) >= epb_r) fos_r <= next_r[s];
          if (!rhead_r[s][EPTR_W-1]) begin
            res_idx_r <= rhead_r[s][EIDX_W-1:0];
            state_r   <= S_AL_LINK;
          end else begin
            if (untch_r[s] != '0) begin
              untch_r[s] <= untch_r[s] - CNT_W'(1);
              res_idx_r  <= EIDX_W'(untch_r[s] - CNT_W'(1));
            end else begin
              res_idx_r <= '0;
            end
            state_r <= S_OUT;
          end
        end

        S_AL_LINK: begin
          rhead_r[cur_r] <= lk_rdata;
          state_r        <= S_OUT;
        end

        // reject a bad free, else push the entry, then unlink the slab if it has to move
        S_FR_CHK: begin
          s   = fslot_r;
          bad = !active_r[s] || (used_r[s] == '0) || ({1'b0, fidx_r} >= epb_r);
          n   = next_r[s];
          p   = prev_r[s];
          ns  = n[SLOT_W-1:0];
          ps  = p[SLOT_W-1:0];
          full_before = used_r[s] >= epb_r;
          cur_r <= s;
          state_r <= S_OUT;
          if (bad) begin
            res_status_r <= ST_BAD_FREE;
          end else begin
            rhead_r[s] <= {1'b0, fidx_r};
            used_r[s]  <= used_r[s] - CNT_W'(1);
            if (full_before) begin
              if ((n != SNULL) && (used_r[ns] >= epb_r)) begin
                if ({1'b0, s} == head_r) head_r <= n;
                next_r[ps] <= (p != SNULL) ? n : next_r[ps];
                prev_r[ns] <= p;
                prev_r[s]  <= SNULL;
                next_r[s]  <= SNULL;
                full_mode_r <= 1'b1;
                state_r     <= S_FR_LINK;
              end else begin
                fos_r <= {1'b0, s};
              end
            end else if ((used_r[s] == CNT_W'(1)) && (n != SNULL) && (used_r[ns] != '0) &&
                         (tail_r != SNULL) && (tail_r != {1'b0, s})) begin
              if ({1'b0, s} == head_r) head_r <= n;
              if ({1'b0, s} == fos_r) fos_r <= n;
              if (p != SNULL) next_r[ps] <= n;
              prev_r[ns] <= p;
              prev_r[s]  <= SNULL;
              next_r[s]  <= SNULL;
              full_mode_r <= 1'b0;
              state_r     <= S_FR_LINK;
            end
          end
        end

        // relink the freed slab ahead of the first open slab, or at the tail
        S_FR_LINK: begin
          s = cur_r;
          state_r <= S_OUT;
          if (full_mode_r && (fos_r != SNULL)) begin
            p  = prev_r[fos_r[SLOT_W-1:0]];
            ps = p[SLOT_W-1:0];
            if (p != SNULL) begin
              n2 = next_r[ps];
              next_r[s] <= n2;
              if (n2 != SNULL) prev_r[n2[SLOT_W-1:0]] <= {1'b0, s};
              prev_r[s]  <= p;
              next_r[ps] <= {1'b0, s};
            end else begin
              next_r[s] <= fos_r;
              prev_r[fos_r[SLOT_W-1:0]] <= {1'b0, s};
              head_r <= {1'b0, s};
            end
          end else begin
            ts = tail_r[SLOT_W-1:0];
            n2 = next_r[ts];
            next_r[s] <= n2;
            if (n2 != SNULL) prev_r[n2[SLOT_W-1:0]] <= {1'b0, s};
            prev_r[s]  <= tail_r;
            next_r[ts] <= {1'b0, s};
            tail_r     <= {1'b0, s};
          end
          if (full_mode_r) fos_r <= {1'b0, s};
        end

        // release the tail slab when it is empty and not the head
        S_REAP: begin
          ts = tail_r[SLOT_W-1:0];
          state_r <= S_OUT;
          if ((head_r != SNULL) && (tail_r != SNULL) && (tail_r != head_r) &&
              (used_r[ts] == '0)) begin
            p  = prev_r[ts];
            ps = p[SLOT_W-1:0];
            if (fos_r == tail_r) fos_r <= SNULL;
            tail_r <= p;
            if (p != SNULL) next_r[ps] <= SNULL;
            active_r[ts] <= 1'b0;
            used_r[ts]   <= '0;
            rhead_r[ts]  <= ENULL;
            untch_r[ts]  <= '0;
            next_r[ts]   <= SNULL;
            prev_r[ts]   <= SNULL;
            res_slot_r   <= ts;
            res_rel_r    <= 1'b1;
          end
        end

        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            out_idx_r    <= res_idx_r;
            out_open_r   <= res_open_r;
            out_rel_r    <= res_rel_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_got_slot      = out_slot_r;
  assign out_got_index     = out_idx_r;
  assign out_slab_opened   = out_open_r;
  assign out_slab_released = out_rel_r;

  `SEA_ASSERT(a_busy_after_take, (in_valid && !in_stall) |=> in_stall)
  `SEA_ASSERT(a_result_held, (out_valid && out_stall) |=> out_valid)
  `SEA_ASSERT(a_head_tail_pair, (head_r == SNULL) == (tail_r == SNULL))
  `SEA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_valid_r)
endmodule

>>> rtl/core/sea_ram.sv
// generic single write port ram with registered read
module sea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
